// File: rtl/pid_controller_clamped_top_macros.svh
// Assertion helpers for the checker file.
`ifndef PID_CONTROLLER_CLAMPED_TOP_MACROS_SVH
`define PID_CONTROLLER_CLAMPED_TOP_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define PIDC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds during reset.
`define PIDC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/pidc_pkg.sv
`default_nettype none

package pidc_pkg;

    localparam int FRAC_BITS          = 16;
    localparam int STEP_W             = 24;
    localparam int TOTAL_W            = 64;
    localparam int DATA_WIDTH_DEF     = 32;
    localparam int INTEGRAL_WIDTH_DEF = 48;
    localparam int CFG_INDEX_W        = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GAIN_PROP  = 3'd0,
        REG_GAIN_INTEG = 3'd1,
        REG_GAIN_DERIV = 3'd2,
        REG_OUT_UPPER  = 3'd3,
        REG_OUT_LOWER  = 3'd4
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SAT,
        ST_ACC,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        OP_INC,
        OP_PROP,
        OP_DERIV,
        OP_INTEG
    } mul_op_t;

    typedef enum logic [1:0] {
        LIMIT_NONE  = 2'd0,
        LIMIT_UPPER = 2'd1,
        LIMIT_LOWER = 2'd2
    } limit_t;

endpackage

`default_nettype wire

// File: rtl/pid_controller_clamped_top.sv
// Clamped PID controller, fixed point. Each sample transaction carries an
// error (signed Q16.16) and the time since the previous sample (unsigned
// Q8.16); each one yields exactly one result transaction with the drive value
// clamped to [out_lower, out_upper] and a flag naming the limit that applied
// (upper is tested first, so crossed limits give out_upper for values above it
// and out_lower otherwise). The block holds the previous error and a
// saturating Q32.16 integral. A zero time step gives a zero derivative and
// leaves the integral as it was. One sample is processed at a time: the block
// is ready again in the same cycle that its result becomes valid. The single
// bit-serial shift-add multiplier forms the integral increment and the three
// gain products one after another, one multiplier bit per cycle. The
// derivative divider, one quotient bit per cycle, runs alongside it. The
// finished result waits in an output register, so the next sample is taken
// while it is still pending; a sample that finishes while the previous
// result is still unread holds until that result is taken. Configuration
// writes are always ready and belong in idle periods.
`default_nettype none

module pid_controller_clamped_top #(
    parameter int DATA_WIDTH     = pidc_pkg::DATA_WIDTH_DEF,
    parameter int INTEGRAL_WIDTH = pidc_pkg::INTEGRAL_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 sample_valid,
    output logic                                 sample_ready,
    input  logic signed [DATA_WIDTH-1:0]         error_sample,
    input  logic [pidc_pkg::STEP_W-1:0]          step_time,

    output logic                                 result_valid,
    input  logic                                 result_ready,
    output logic signed [DATA_WIDTH-1:0]         drive_value,
    output logic [1:0]                           limit_hit,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pidc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [DATA_WIDTH-1:0]                cfg_data
);
    import pidc_pkg::*;

    localparam int DW  = DATA_WIDTH;
    localparam int IW  = INTEGRAL_WIDTH;
    localparam int MW  = (IW > DW) ? IW : DW;
    localparam int SW  = ((DW > STEP_W) ? DW : STEP_W) + 1;
    localparam int PW  = MW + 1 + SW;
    localparam int SHW = PW - FRAC_BITS;
    localparam int EW  = (SHW > TOTAL_W + 1) ? SHW : TOTAL_W + 1;
    localparam int CW  = $clog2(SW);

    localparam logic signed [EW-1:0] S64_MAX_E =
        {{(EW-TOTAL_W+1){1'b0}}, {(TOTAL_W-1){1'b1}}};
    localparam logic signed [EW-1:0] S64_MIN_E =
        {{(EW-TOTAL_W+1){1'b1}}, {(TOTAL_W-1){1'b0}}};
    localparam logic signed [TOTAL_W-1:0] S64_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};
    localparam logic signed [TOTAL_W-1:0] S64_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};
    localparam logic signed [TOTAL_W:0] INTEG_MAX =
        {{(TOTAL_W+2-IW){1'b0}}, {(IW-1){1'b1}}};
    localparam logic signed [TOTAL_W:0] INTEG_MIN =
        {{(TOTAL_W+2-IW){1'b1}}, {(IW-1){1'b0}}};
    localparam logic [DW-1:0] DATA_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] DATA_MIN = {1'b1, {(DW-1){1'b0}}};

    // control
    state_t                     state_reg, state_next;
    mul_op_t                    op_reg, op_next;
    logic [CW-1:0]              cnt_reg, cnt_next;
    logic                       result_valid_reg;

    // configuration and loop state
    logic signed [DW-1:0]       gain_prop_reg;
    logic signed [DW-1:0]       gain_integ_reg;
    logic signed [DW-1:0]       gain_deriv_reg;
    logic signed [DW-1:0]       out_upper_reg;
    logic signed [DW-1:0]       out_lower_reg;
    logic signed [DW-1:0]       last_error_reg;
    logic signed [IW-1:0]       integral_reg, integral_next;

    // datapath
    logic signed [DW-1:0]       error_reg;
    logic signed [MW-1:0]       mcand_reg, mcand_next;
    logic [SW-1:0]              ser_reg, ser_next;
    logic signed [MW:0]         acc_hi_reg, acc_hi_next;
    logic [SW-1:0]              acc_lo_reg, acc_lo_next;
    logic signed [TOTAL_W-1:0]  prod_sat_reg, prod_sat_next;
    logic signed [TOTAL_W-1:0]  total_reg, total_next;
    logic signed [DW-1:0]       drive_value_reg, drive_value_next;
    limit_t                     limit_hit_reg, limit_hit_next;

    logic                       accept;
    logic                       acc_advance;
    logic                       load_out;
    logic                       mul_last;
    logic signed [MW+1:0]       addend;
    logic signed [MW+1:0]       acc_ext;
    logic signed [MW+1:0]       mul_sum;
    logic signed [PW-1:0]       product;
    logic signed [SHW-1:0]      prod_shift;
    logic signed [EW-1:0]       prod_ext;
    logic signed [TOTAL_W:0]    total_sum;
    logic signed [TOTAL_W-1:0]  total_sat;
    logic signed [TOTAL_W:0]    integ_sum;
    logic signed [IW-1:0]       integ_sat;
    logic signed [TOTAL_W-1:0]  upper_ext;
    logic signed [TOTAL_W-1:0]  lower_ext;
    logic signed [DW:0]         diff_val;
    logic signed [DW-1:0]       deriv;
    logic                       div_busy;

    assign diff_val = (DW+1)'(error_sample) - (DW+1)'(last_error_reg);

    pidc_deriv_div #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_deriv_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .diff  (diff_val),
        .step  (step_time),
        .deriv (deriv),
        .busy  (div_busy)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (mul_last)
                begin
                    state_next = ST_SAT;
                end
            end
            ST_SAT:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (acc_advance)
                begin
                    state_next = (op_reg == OP_INTEG) ? ST_DONE : ST_MUL;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        sample_ready = 1'b0;
        accept       = 1'b0;
        acc_advance  = 1'b0;
        load_out     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                sample_ready = 1'b1;
                accept       = sample_valid;
            end
            ST_ACC:
            begin
                // hold before the derivative product until the quotient is in
                acc_advance = !(op_reg == OP_PROP && div_busy);
            end
            ST_DONE:
            begin
                load_out = !result_valid_reg || result_ready;
            end
            default:
            begin
                sample_ready = 1'b0;
            end
        endcase
    end

    // shift-add multiplier step and result shaping
    always_comb
    begin
        mul_last   = (cnt_reg == CW'(SW-1));
        addend     = ser_reg[0] ? (MW+2)'(mcand_reg) : '0;
        acc_ext    = (MW+2)'(acc_hi_reg);
        // the top multiplier bit carries negative weight
        mul_sum    = mul_last ? (acc_ext - addend) : (acc_ext + addend);
        product    = $signed({acc_hi_reg, acc_lo_reg});
        prod_shift = product[PW-1:FRAC_BITS];
        prod_ext   = EW'(prod_shift);
        if (prod_ext > S64_MAX_E)
        begin
            prod_sat_next = S64_MAX;
        end
        else if (prod_ext < S64_MIN_E)
        begin
            prod_sat_next = S64_MIN;
        end
        else
        begin
            prod_sat_next = prod_ext[TOTAL_W-1:0];
        end

        total_sum = (TOTAL_W+1)'(total_reg) + (TOTAL_W+1)'(prod_sat_reg);
        if (total_sum[TOTAL_W] != total_sum[TOTAL_W-1])
        begin
            total_sat = total_sum[TOTAL_W] ? S64_MIN : S64_MAX;
        end
        else
        begin
            total_sat = total_sum[TOTAL_W-1:0];
        end

        integ_sum = (TOTAL_W+1)'(integral_reg) + (TOTAL_W+1)'(prod_sat_reg);
        if (integ_sum > INTEG_MAX)
        begin
            integ_sat = INTEG_MAX[IW-1:0];
        end
        else if (integ_sum < INTEG_MIN)
        begin
            integ_sat = INTEG_MIN[IW-1:0];
        end
        else
        begin
            integ_sat = integ_sum[IW-1:0];
        end

        upper_ext = TOTAL_W'(out_upper_reg);
        lower_ext = TOTAL_W'(out_lower_reg);
    end

    // datapath next values
    always_comb
    begin
        op_next          = op_reg;
        cnt_next         = cnt_reg;
        mcand_next       = mcand_reg;
        ser_next         = ser_reg;
        acc_hi_next      = acc_hi_reg;
        acc_lo_next      = acc_lo_reg;
        total_next       = total_reg;
        integral_next    = integral_reg;
        drive_value_next = drive_value_reg;
        limit_hit_next   = limit_hit_reg;

        if (accept)
        begin
            op_next     = OP_INC;
            cnt_next    = '0;
            mcand_next  = MW'(error_sample);
            ser_next    = SW'(step_time);
            acc_hi_next = '0;
            acc_lo_next = '0;
            total_next  = '0;
        end

        if (state_reg == ST_MUL)
        begin
            cnt_next    = mul_last ? '0 : cnt_reg + 1'b1;
            acc_hi_next = mul_sum[MW+1:1];
            acc_lo_next = {mul_sum[0], acc_lo_reg[SW-1:1]};
            ser_next    = ser_reg >> 1;
        end

        if (acc_advance)
        begin
            cnt_next    = '0;
            acc_hi_next = '0;
            acc_lo_next = '0;
            case (op_reg)
                OP_INC:
                begin
                    integral_next = integ_sat;
                    op_next       = OP_PROP;
                    mcand_next    = MW'(error_reg);
                    ser_next      = SW'(gain_prop_reg);
                end
                OP_PROP:
                begin
                    total_next = total_sat;
                    op_next    = OP_DERIV;
                    mcand_next = MW'(deriv);
                    ser_next   = SW'(gain_deriv_reg);
                end
                OP_DERIV:
                begin
                    total_next = total_sat;
                    op_next    = OP_INTEG;
                    mcand_next = MW'(integral_reg);
                    ser_next   = SW'(gain_integ_reg);
                end
                OP_INTEG:
                begin
                    total_next = total_sat;
                end
                default:
                begin
                    op_next = OP_INC;
                end
            endcase
        end

        if (load_out)
        begin
            if (total_reg > upper_ext)
            begin
                drive_value_next = out_upper_reg;
                limit_hit_next   = LIMIT_UPPER;
            end
            else if (total_reg < lower_ext)
            begin
                drive_value_next = out_lower_reg;
                limit_hit_next   = LIMIT_LOWER;
            end
            else
            begin
                drive_value_next = total_reg[DW-1:0];
                limit_hit_next   = LIMIT_NONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            op_reg           <= OP_INC;
            cnt_reg          <= '0;
            result_valid_reg <= 1'b0;
            gain_prop_reg    <= '0;
            gain_integ_reg   <= '0;
            gain_deriv_reg   <= '0;
            out_upper_reg    <= $signed(DATA_MAX);
            out_lower_reg    <= $signed(DATA_MIN);
            last_error_reg   <= '0;
            integral_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            cnt_reg      <= cnt_next;
            integral_reg <= integral_next;
            if (accept)
            begin
                last_error_reg <= error_sample;
            end
            if (load_out)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_GAIN_PROP:  gain_prop_reg  <= cfg_data;
                    REG_GAIN_INTEG: gain_integ_reg <= cfg_data;
                    REG_GAIN_DERIV: gain_deriv_reg <= cfg_data;
                    REG_OUT_UPPER:  out_upper_reg  <= cfg_data;
                    REG_OUT_LOWER:  out_lower_reg  <= cfg_data;
                    default:        ; // drop writes to unknown indexes
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            error_reg <= error_sample;
        end
        mcand_reg       <= mcand_next;
        ser_reg         <= ser_next;
        acc_hi_reg      <= acc_hi_next;
        acc_lo_reg      <= acc_lo_next;
        prod_sat_reg    <= prod_sat_next;
        total_reg       <= total_next;
        drive_value_reg <= drive_value_next;
        limit_hit_reg   <= limit_hit_next;
    end

    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign drive_value  = drive_value_reg;
    assign limit_hit    = limit_hit_reg;

endmodule

`default_nettype wire

// File: rtl/pidc_deriv_div.sv
`default_nettype none

module pidc_deriv_div #(
    parameter int DATA_WIDTH = pidc_pkg::DATA_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic signed [DATA_WIDTH:0]     diff,
    input  logic [pidc_pkg::STEP_W-1:0]    step,
    output logic signed [DATA_WIDTH-1:0]   deriv,
    output logic                           busy
);
    import pidc_pkg::*;

    localparam int NW = DATA_WIDTH + 1 + FRAC_BITS;
    localparam int CW = $clog2(NW);

    localparam logic [NW-1:0] LIM_POS =
        {{(NW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [NW-1:0] LIM_NEG =
        {{(NW-DATA_WIDTH){1'b0}}, 1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] MAX_VAL = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic                busy_reg;
    logic [CW-1:0]       cnt_reg;
    logic [NW-1:0]       work_reg;
    logic [STEP_W-1:0]   rem_reg;
    logic [STEP_W-1:0]   div_reg;
    logic                neg_reg;
    logic                zero_reg;

    logic [STEP_W:0]     trial;
    logic                fits;
    logic [STEP_W-1:0]   rem_next;
    logic [DATA_WIDTH:0] diff_mag;
    logic [NW-1:0]       q_neg;

    // Restoring division: one quotient bit per cycle, shifted into the
    // bottom of the dividend register as the dividend leaves the top.
    always_comb
    begin
        trial    = {rem_reg, work_reg[NW-1]};
        fits     = trial >= {1'b0, div_reg};
        rem_next = fits ? STEP_W'(trial - {1'b0, div_reg}) : trial[STEP_W-1:0];
        diff_mag = diff[DATA_WIDTH] ? (DATA_WIDTH+1)'(-diff) : diff;
        q_neg    = ~work_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CW'(NW-1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= {diff_mag, {FRAC_BITS{1'b0}}};
            rem_reg  <= '0;
            div_reg  <= step;
            neg_reg  <= diff[DATA_WIDTH];
            zero_reg <= (step == '0);
        end
        else if (busy_reg)
        begin
            work_reg <= {work_reg[NW-2:0], fits};
            rem_reg  <= rem_next;
        end
    end

    // Apply sign and saturate the quotient to the data range.
    always_comb
    begin
        if (zero_reg)
        begin
            deriv = '0;
        end
        else if (neg_reg)
        begin
            deriv = (work_reg > LIM_NEG) ? $signed(MIN_VAL) : $signed(q_neg[DATA_WIDTH-1:0]);
        end
        else
        begin
            deriv = (work_reg > LIM_POS) ? $signed(MAX_VAL)
                                         : $signed(work_reg[DATA_WIDTH-1:0]);
        end
    end

    assign busy = busy_reg;

endmodule

`default_nettype wire

// File: rtl/pidc_checker.sv
`default_nettype none

`include "pid_controller_clamped_top_macros.svh"

module pidc_checker #(
    parameter int DATA_WIDTH = pidc_pkg::DATA_WIDTH_DEF
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   sample_valid,
    input logic                   sample_ready,
    input logic                   result_valid,
    input logic                   result_ready,
    input logic [DATA_WIDTH-1:0]  drive_value,
    input logic [1:0]             limit_hit
);

    // one sample in flight: a taken transaction closes the input side
    `PIDC_ASSERT(a_one_in_flight, sample_valid && sample_ready |=> !sample_ready, "sample taken while busy")

    // a result never shows up right after a sample transaction
    `PIDC_ASSERT(a_no_instant_result, sample_valid && sample_ready |=> !$rose(result_valid), "result too early")

    // a stalled result holds its payload
    `PIDC_ASSERT(a_result_hold, result_valid && !result_ready |=> result_valid && $stable(drive_value) && $stable(limit_hit), "stalled result changed")

    // reset leaves the block empty and ready
    `PIDC_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !result_valid && sample_ready, "not idle in reset")

endmodule

bind pid_controller_clamped_top pidc_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_pidc_checker (.*);

`default_nettype wire

// File: dv/tb_pid_controller_clamped_top.sv
`timescale 1ns / 1ps

module tb_pid_controller_clamped_top;
    import pidc_pkg::*;

    localparam int DW = DATA_WIDTH_DEF;
    localparam int IW = INTEGRAL_WIDTH_DEF;
    localparam logic [DW-1:0] DATA_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] DATA_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] ONE_Q16 = 1 << FRAC_BITS;
    localparam int FIRST_UNUSED_REG = REG_OUT_LOWER + 1;
    localparam int LAST_REG_INDEX = (1 << CFG_INDEX_W) - 1;
    localparam int DRAIN_LIMIT = 100000;

    typedef enum int {
        STYLE_ANY,
        STYLE_SMALL,
        STYLE_EDGE,
        STYLE_DRIFT,
        STYLE_WINDUP
    } err_style_t;

    typedef struct {
        logic signed [DW-1:0] drive;
        limit_t               flag;
    } pid_output_t;

    class pid_loop_model;
        longint gain_p, gain_i, gain_d, lim_hi, lim_lo;
        longint prev_error, integral;
        pid_output_t drive_queue[$];
        int mismatches;

        function new();
            gain_p = 0;
            gain_i = 0;
            gain_d = 0;
            lim_hi = $signed(DATA_MAX);
            lim_lo = $signed(DATA_MIN);
            prev_error = 0;
            integral = 0;
            mismatches = 0;
        endfunction

        static function longint clip(logic signed [127:0] v, int w);
            logic signed [127:0] hi, lo;
            hi = (128'sd1 <<< (w - 1)) - 128'sd1;
            lo = -hi - 128'sd1;
            if (v > hi)
                return hi[63:0];
            if (v < lo)
                return lo[63:0];
            return v[63:0];
        endfunction

        static function longint add_sat(longint a, longint b);
            logic signed [127:0] wa, wb;
            wa = a;
            wb = b;
            return clip(wa + wb, 64);
        endfunction

        // floor(a * b / 2^16), held to the 64-bit range
        static function longint mul_q16(longint a, longint b);
            logic signed [127:0] wa, wb;
            wa = a;
            wb = b;
            return clip((wa * wb) >>> FRAC_BITS, 64);
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [DW-1:0] data);
            longint v;
            v = $signed(data);
            case (idx)
                REG_GAIN_PROP:  gain_p = v;
                REG_GAIN_INTEG: gain_i = v;
                REG_GAIN_DERIV: gain_d = v;
                REG_OUT_UPPER:  lim_hi = v;
                REG_OUT_LOWER:  lim_lo = v;
                default: ;
            endcase
        endfunction

        function void take_sample(logic signed [DW-1:0] err, logic [STEP_W-1:0] dt);
            longint e, step, diff, q, deriv, total;
            logic [63:0] m;
            pid_output_t res;
            e = err;
            step = dt;
            deriv = 0;
            if (step != 0)
            begin
                diff = e - prev_error;
                m = (diff < 0) ? -diff : diff;
                q = longint'((m << FRAC_BITS) / step);
                deriv = clip((diff < 0) ? -q : q, DW);
            end
            integral = clip(add_sat(integral, mul_q16(e, step)), IW);
            prev_error = e;

            total = mul_q16(gain_p, e);
            total = add_sat(total, mul_q16(gain_d, deriv));
            total = add_sat(total, mul_q16(gain_i, integral));

            // upper test first, so crossed limits fall through to the lower one
            if (total > lim_hi)
            begin
                res.drive = lim_hi[DW-1:0];
                res.flag = LIMIT_UPPER;
            end
            else if (total < lim_lo)
            begin
                res.drive = lim_lo[DW-1:0];
                res.flag = LIMIT_LOWER;
            end
            else
            begin
                res.drive = total[DW-1:0];
                res.flag = LIMIT_NONE;
            end
            drive_queue.push_back(res);
        endfunction

        function int pending();
            return drive_queue.size();
        endfunction

        function void check_result(logic signed [DW-1:0] drive, logic [1:0] flag);
            pid_output_t want;
            if (drive_queue.size() == 0)
            begin
                $error("result with no sample outstanding: drive_value %0d, limit_hit %0d",
                       drive, flag);
                mismatches++;
                return;
            end
            want = drive_queue.pop_front();
            if (drive !== want.drive)
            begin
                $error("drive_value: expected %0d, actual %0d", want.drive, drive);
                mismatches++;
            end
            if (flag !== want.flag)
            begin
                $error("limit_hit: expected %0d, actual %0d", want.flag, flag);
                mismatches++;
            end
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        sample_valid;
    logic                        sample_ready;
    logic signed [DW-1:0]        error_sample;
    logic [STEP_W-1:0]           step_time;
    logic                        result_valid;
    logic                        result_ready;
    logic signed [DW-1:0]        drive_value;
    logic [1:0]                  limit_hit;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_INDEX_W-1:0]      cfg_index;
    logic [DW-1:0]               cfg_data;

    pid_loop_model loop_model;

    pid_controller_clamped_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .error_sample (error_sample),
        .step_time    (step_time),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .drive_value  (drive_value),
        .limit_hit    (limit_hit),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

    // result side: change stall behavior every so often
    initial
    begin
        int mode, span;
        result_ready = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = (mode == 3) ? $urandom_range(10, 150) : $urandom_range(10, 300);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    0: result_ready <= 1'b1;
                    1: result_ready <= ($urandom_range(0, 1) == 1);
                    2: result_ready <= ($urandom_range(0, 7) == 0);
                    default: result_ready <= 1'b0;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            loop_model.check_result(drive_value, limit_hit);
    end

    task automatic send_sample(logic [DW-1:0] err, logic [STEP_W-1:0] dt);
        sample_valid <= 1'b1;
        error_sample <= err;
        step_time <= dt;
        do @(posedge clk); while (!sample_ready);
        loop_model.take_sample(err, dt);
        @(negedge clk);
    endtask

    task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [DW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        loop_model.set_register(idx, data);
        @(negedge clk);
    endtask

    // hold cfg_valid across the writes, drop it once at the end
    task automatic configure(logic [DW-1:0] kp, logic [DW-1:0] ki, logic [DW-1:0] kd,
                             logic [DW-1:0] upper, logic [DW-1:0] lower);
        write_register(REG_GAIN_PROP, kp);
        write_register(REG_GAIN_INTEG, ki);
        write_register(REG_GAIN_DERIV, kd);
        write_register(REG_OUT_UPPER, upper);
        write_register(REG_OUT_LOWER, lower);
        write_register(CFG_INDEX_W'($urandom_range(FIRST_UNUSED_REG, LAST_REG_INDEX)), $urandom);
        cfg_valid <= 1'b0;
    endtask

    task automatic end_phase();
        int waited;
        waited = 0;
        sample_valid <= 1'b0;
        while (loop_model.pending() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (8) @(negedge clk);
    endtask

    function automatic logic [DW-1:0] pick_error(err_style_t style, bit neg);
        logic [DW-1:0] m;
        case (style)
            STYLE_ANY:   return $urandom;
            STYLE_SMALL: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            STYLE_EDGE:
            begin
                case ($urandom_range(0, 4))
                    0: return DATA_MAX;
                    1: return DATA_MIN;
                    2: return '0;
                    3: return 1;
                    default: return '1;
                endcase
            end
            STYLE_DRIFT: m = $urandom_range(32'h0100_0000, 32'h7fff_ffff);
            default:     m = $urandom_range(32'h7000_0000, 32'h7fff_ffff);
        endcase
        return neg ? -m : m;
    endfunction

    function automatic logic [STEP_W-1:0] pick_step(err_style_t style);
        if (style == STYLE_WINDUP)
            return $urandom_range(24'hE0_0000, 24'hFF_FFFF);
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 1;
            2: return '1;
            3, 4: return STEP_W'($urandom);
            default: return $urandom_range(1, 24'h00_FFFF);
        endcase
    endfunction

    function automatic logic [DW-1:0] pick_gain();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            2:
            begin
                case ($urandom_range(0, 2))
                    0: return DATA_MAX;
                    1: return DATA_MIN;
                    default: return '0;
                endcase
            end
            default: return $urandom_range(0, 1) ? ONE_Q16 : -ONE_Q16;
        endcase
    endfunction

    task automatic random_config();
        logic [DW-1:0] a, b, up, lo;
        a = $urandom;
        b = $urandom;
        case ($urandom_range(0, 3))
            0:
            begin
                up = DATA_MAX;
                lo = DATA_MIN;
            end
            1:
            begin
                up = ($signed(a) > $signed(b)) ? a : b;
                lo = ($signed(a) > $signed(b)) ? b : a;
            end
            2:
            begin
                up = ($signed(a) > $signed(b)) ? b : a;
                lo = ($signed(a) > $signed(b)) ? a : b;
            end
            default:
            begin
                up = $urandom_range(0, 32'h0010_0000);
                lo = -$urandom_range(0, 32'h0010_0000);
            end
        endcase
        configure(pick_gain(), pick_gain(), pick_gain(), up, lo);
    endtask

    task automatic run_random_phase(int count, bit windup, bit windup_neg);
        int sent, burst, gap;
        err_style_t style;
        bit neg;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 16);
            neg = windup ? windup_neg : $urandom_range(0, 1);
            repeat (burst)
            begin
                if (windup)
                    style = ($urandom_range(0, 9) == 0) ? STYLE_ANY : STYLE_WINDUP;
                else
                    style = err_style_t'($urandom_range(STYLE_ANY, STYLE_DRIFT));
                send_sample(pick_error(style, neg), pick_step(style));
                sent++;
            end
            case ($urandom_range(0, 7))
                0, 1: gap = 0;
                2, 3: gap = $urandom_range(1, 160);
                default: gap = $urandom_range(1, 8);
            endcase
            if (gap > 0)
            begin
                sample_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        end_phase();
    endtask

    initial
    begin
        loop_model = new();
        rst_n = 1'b0;
        sample_valid = 1'b0;
        error_sample = '0;
        step_time = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset values: zero gains, widest limits
        send_sample(DATA_MAX, '1);
        send_sample(DATA_MIN, 1);
        end_phase();

        // unit gains, derivative saturation both ways, zero step
        configure(ONE_Q16, ONE_Q16, ONE_Q16, DATA_MAX, DATA_MIN);
        send_sample(DATA_MAX, 1);
        send_sample(DATA_MIN, 1);
        send_sample(DATA_MIN, '1);
        send_sample(DATA_MAX, 0);
        send_sample(1, '1);
        send_sample('1, 1);
        send_sample(0, 0);
        send_sample(32'h0001_2345, 24'h01_0000);
        end_phase();

        // extreme gains drive the 64-bit sum far beyond the data range
        configure(DATA_MAX, DATA_MIN, DATA_MAX, DATA_MAX, DATA_MIN);
        send_sample(DATA_MAX, 1);
        send_sample(DATA_MIN, 1);
        send_sample(DATA_MAX, '1);
        send_sample(DATA_MIN, '1);
        end_phase();

        // crossed limits: upper -1.0, lower +1.0
        configure(ONE_Q16, '0, '0, -ONE_Q16, ONE_Q16);
        send_sample(32'h0002_0000, 0);
        send_sample(0, 0);
        send_sample(-32'h0002_0000, 0);
        send_sample(-ONE_Q16, 0);
        end_phase();

        // narrow window, values beyond both limits, inside and on the upper one
        configure(ONE_Q16, '0, '0, ONE_Q16, -ONE_Q16);
        send_sample(32'h0002_0000, 0);
        send_sample(-32'h0002_0000, 0);
        send_sample(32'h0000_8000, 0);
        send_sample(ONE_Q16, 0);
        end_phase();

        for (int p = 0; p < 8; p++)
        begin
            if (p == 1)
            begin
                // wind the integral down to its floor; the smallest integral gain shows it
                configure('0, 1, '0, DATA_MAX, DATA_MIN);
                run_random_phase(380, 1'b1, 1'b1);
            end
            else
            begin
                random_config();
                run_random_phase(160, 1'b0, 1'b0);
            end
        end

        repeat (20) @(negedge clk);
        if (loop_model.pending() != 0)
            $error("%0d expected results never arrived", loop_model.pending());
        if (loop_model.mismatches == 0 && loop_model.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
